// ----- hw/rtl/text_console_writer_assert.svh -----
// Assertion macros for the console RTL.
// Each macro expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

    // Operation codes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_SET   = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ATTRIBUTE    = 2'd0;
    localparam logic [1:0] CFG_COLUMNS      = 2'd1;
    localparam logic [1:0] CFG_ROWS         = 2'd2;
    localparam logic [1:0] CFG_CURSOR_SHOWN = 2'd3;

    // Character and cell constants
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  RESET_ATTR   = 8'h07;
    localparam logic [6:0]  RESET_COLS   = 7'd80;
    localparam logic [4:0]  RESET_ROWS   = 5'd25;
    localparam logic [15:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        char_code;
        logic signed [7:0] want_column;
        logic signed [7:0] want_row;
        logic [10:0]       cell_index;
    } req_t;

    typedef struct packed {
        logic [7:0]  char_echo;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_location;
        logic        cursor_write;
        logic        scrolled;
        logic [15:0] cell_value;
    } rsp_t;

    // Cursor step result handed from the cursor unit to the sequencer
    typedef struct packed {
        logic [6:0]  column;
        logic [4:0]  row;
        logic        put_we;
        logic [11:0] put_addr;
        logic        scroll;
    } cursor_upd_t;

    // Linear cell location of a row and column on a screen of given width
    function automatic logic [11:0] cell_loc(input logic [4:0] row,
                                             input logic [6:0] col,
                                             input logic [6:0] width);
        logic [11:0] prod;
        prod = {7'd0, row} * {5'd0, width};
        return prod + {5'd0, col};
    endfunction

endpackage

// ----- hw/rtl/text_console_writer.sv -----
// Set cursor, read cell and a put character that does not scroll go through the execute
//   and done states; a new request is taken when idle or as a result is handed on.
// A scrolling put character then shifts the screen up a row and blanks the last, one cell a cycle.
// Clear sweeps the whole store one cell per cycle.
// Reset: control state clears at once, then a pass over the whole store fills it
//   with light gray spaces; requests are stalled until it ends.
module text_console_writer #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tcw_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tcw_pkg::rsp_t rsp_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

`include "text_console_writer_assert.svh"

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] DEPTH_W = 17'(DEPTH);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Cell store and its read register
    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [2:0]    state_reg, state_next;
    tcw_pkg::req_t req_reg, req_next;
    logic [6:0]    cur_col_reg, cur_col_next;
    logic [4:0]    cur_row_reg, cur_row_next;
    logic [7:0]    attr_reg;
    logic [6:0]    cols_reg;
    logic [4:0]    rows_reg;
    logic          shown_reg;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [11:0]   scroll_reg, scroll_next;
    logic [11:0]   moved_reg, moved_next;
    logic [7:0]    echo_reg, echo_next;
    logic          curw_reg, curw_next;
    logic          scr_reg, scr_next;
    logic          hit_reg, hit_next;
    logic          rsp_valid_reg, rsp_valid_next;
    tcw_pkg::rsp_t rsp_reg, rsp_next;

    logic [6:0]           eff_w;
    logic [4:0]           eff_h;
    logic [11:0]          scroll_total;
    logic [11:0]          scroll_wr;
    logic [15:0]          blank;
    logic                 out_free;
    logic                 accept;
    logic                 idx_hit;
    tcw_pkg::cursor_upd_t upd;

    // Clamp the geometry registers to what the store holds
    always_comb
    begin
        if (cols_reg == 7'd0)
            eff_w = 7'd1;
        else if ({2'b0, cols_reg} > 9'(MAX_COLUMNS))
            eff_w = 7'(MAX_COLUMNS);
        else
            eff_w = cols_reg;

        if (rows_reg == 5'd0)
            eff_h = 5'd1;
        else if ({3'b0, rows_reg} > 8'(MAX_ROWS))
            eff_h = 5'(MAX_ROWS);
        else
            eff_h = rows_reg;
    end

    tcw_cursor u_cursor (
        .req        (req_reg),
        .cur_column (cur_col_reg),
        .cur_row    (cur_row_reg),
        .columns    (eff_w),
        .rows       (eff_h),
        .upd        (upd)
    );

    assign blank        = {attr_reg, tcw_pkg::SPACE_CODE};
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign req_stall    = !((state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free));
    assign accept       = req_valid && !req_stall;
    assign cfg_ready    = 1'b1;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_data     = rsp_reg;
    assign scroll_total = moved_reg + {5'd0, eff_w};
    assign scroll_wr    = scroll_reg - 12'd1;
    assign idx_hit      = {6'd0, req_reg.cell_index} < DEPTH_W;

    // Sequence requests, sweeps and scrolls over the read and write ports of the cell store
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        sweep_next     = sweep_reg;
        scroll_next    = scroll_reg;
        moved_next     = moved_reg;
        echo_next      = echo_reg;
        curw_next      = curw_reg;
        scr_next       = scr_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg;
        mem_wdata      = blank;
        mem_re         = 1'b0;
        mem_raddr      = AW'(req_reg.cell_index);

        case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = tcw_pkg::RESET_CELL;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                cur_col_next = upd.column;
                cur_row_next = upd.row;
                echo_next    = 8'd0;
                curw_next    = 1'b0;
                scr_next     = 1'b0;
                hit_next     = 1'b0;
                moved_next   = {7'd0, eff_h - 5'd1} * {5'd0, eff_w};
                scroll_next  = 12'd0;
                sweep_next   = '0;
                state_next   = S_DONE;
                case (req_reg.mode)
                    tcw_pkg::MODE_PUT:
                    begin
                        echo_next = req_reg.char_code;
                        curw_next = shown_reg;
                        scr_next  = upd.scroll;
                        mem_we    = upd.put_we;
                        mem_waddr = AW'(upd.put_addr);
                        mem_wdata = {attr_reg, req_reg.char_code};
                        if (upd.scroll)
                            state_next = S_SCROLL;
                    end
                    tcw_pkg::MODE_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    tcw_pkg::MODE_SET:
                    begin
                        curw_next = shown_reg;
                    end
                    default:
                    begin
                        hit_next = idx_hit;
                        mem_re   = idx_hit;
                    end
                endcase
            end
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = S_DONE;
                end
            end
            S_SCROLL:
            begin
                // Read one row below, write the cell fetched last cycle
                mem_re    = scroll_reg < moved_reg;
                mem_raddr = AW'(scroll_reg + {5'd0, eff_w});
                if (scroll_reg != 12'd0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(scroll_wr);
                    mem_wdata = (scroll_wr < moved_reg) ? rd_data_reg : blank;
                end
                scroll_next = scroll_reg + 12'd1;
                if (scroll_reg == scroll_total)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.char_echo       = echo_reg;
                    rsp_next.cursor_column   = cur_col_reg;
                    rsp_next.cursor_row      = cur_row_reg;
                    rsp_next.cursor_location =
                        11'(tcw_pkg::cell_loc(cur_row_reg, cur_col_reg, eff_w));
                    rsp_next.cursor_write    = curw_reg;
                    rsp_next.scrolled        = scr_reg;
                    rsp_next.cell_value      = hit_reg ? rd_data_reg : 16'd0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Take a new request
        if (accept)
        begin
            req_next   = req_data;
            state_next = S_EXEC;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cur_col_reg   <= 7'd0;
            cur_row_reg   <= 5'd0;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            cols_reg      <= tcw_pkg::RESET_COLS;
            rows_reg      <= tcw_pkg::RESET_ROWS;
            shown_reg     <= 1'b0;
            sweep_reg     <= '0;
            scroll_reg    <= 12'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sweep_reg     <= sweep_next;
            scroll_reg    <= scroll_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tcw_pkg::CFG_ATTRIBUTE:    attr_reg  <= cfg_data;
                    tcw_pkg::CFG_COLUMNS:      cols_reg  <= cfg_data[6:0];
                    tcw_pkg::CFG_ROWS:         rows_reg  <= cfg_data[4:0];
                    tcw_pkg::CFG_CURSOR_SHOWN: shown_reg <= cfg_data[0];
                    default:                   shown_reg <= shown_reg;
                endcase
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        moved_reg <= moved_next;
        echo_reg  <= echo_next;
        curw_reg  <= curw_next;
        scr_reg   <= scr_next;
        hit_reg   <= hit_next;
        rsp_reg   <= rsp_next;
    end

    // Access the cell store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    `TCW_ASSERT_NOW(a_accept_state, accept, (state_reg == S_IDLE) || (state_reg == S_DONE), "request taken while busy")
    `TCW_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "taken request not executed")
    `TCW_ASSERT_NOW(a_write_range, mem_we, {{(17-AW){1'b0}}, mem_waddr} < DEPTH_W, "store write out of range")
    `TCW_ASSERT_NOW(a_port_overlap, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one cell")
    `TCW_ASSERT_NOW(a_scroll_bound, state_reg == S_SCROLL, scroll_reg <= scroll_total, "scroll ran past its end")

endmodule

// ----- hw/rtl/tcw_cursor.sv -----
module tcw_cursor (
    input  tcw_pkg::req_t        req,
    input  logic [6:0]           cur_column,
    input  logic [4:0]           cur_row,
    input  logic [6:0]           columns,
    input  logic [4:0]           rows,
    output tcw_pkg::cursor_upd_t upd
);

    logic [6:0] col_c;
    logic [4:0] row_c;
    logic [7:0] col_inc;
    logic [5:0] row_inc;
    logic [5:0] row_put;
    logic [6:0] set_col;
    logic [4:0] set_row;

    // Clamp the stored cursor into the screen in use
    assign col_c   = (cur_column >= columns) ? columns - 7'd1 : cur_column;
    assign row_c   = (cur_row >= rows) ? rows - 5'd1 : cur_row;
    assign col_inc = {1'b0, col_c} + 8'd1;
    assign row_inc = {1'b0, row_c} + 6'd1;

    // Clamp a requested position, negative to zero, past the edge to the last
    always_comb
    begin
        if (req.want_column[7])
            set_col = 7'd0;
        else if ({1'b0, req.want_column[6:0]} >= {1'b0, columns})
            set_col = columns - 7'd1;
        else
            set_col = req.want_column[6:0];

        if (req.want_row[7])
            set_row = 5'd0;
        else if ({1'b0, req.want_row[6:0]} >= {3'b0, rows})
            set_row = rows - 5'd1;
        else
            set_row = req.want_row[4:0];
    end

    // Step the cursor for the requested operation
    always_comb
    begin
        upd.column   = col_c;
        upd.row      = row_c;
        upd.put_we   = 1'b0;
        upd.put_addr = tcw_pkg::cell_loc(row_c, col_c, columns);
        upd.scroll   = 1'b0;
        row_put      = {1'b0, row_c};

        case (req.mode)
            tcw_pkg::MODE_PUT:
            begin
                if (req.char_code == tcw_pkg::NEWLINE_CODE)
                begin
                    upd.column = 7'd0;
                    row_put    = row_inc;
                end
                else
                begin
                    upd.put_we = 1'b1;
                    if (col_inc == {1'b0, columns})
                    begin
                        upd.column = 7'd0;
                        row_put    = row_inc;
                    end
                    else
                    begin
                        upd.column = col_inc[6:0];
                    end
                end
                // Passing the last row scrolls and holds the cursor on it
                if (row_put == {1'b0, rows})
                begin
                    upd.row    = rows - 5'd1;
                    upd.scroll = 1'b1;
                end
                else
                begin
                    upd.row = row_put[4:0];
                end
            end
            tcw_pkg::MODE_SET:
            begin
                upd.column = set_col;
                upd.row    = set_row;
            end
            default:
            begin
                upd.column = col_c;
                upd.row    = row_c;
            end
        endcase
    end

endmodule

// ----- dv/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int PHASES      = 12;

    typedef struct {
        tcw_pkg::req_t op;
        bit            typed;
        tcw_pkg::rsp_t reply;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    tcw_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    tcw_pkg::rsp_t rsp_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // Shadow copy of the console: cells, cursor and registers
    logic [15:0] cells [CELL_COUNT];
    int cursor_col = 0;
    int cursor_row = 0;
    logic [7:0] attr_reg = tcw_pkg::RESET_ATTR;
    logic [6:0] cols_reg = tcw_pkg::RESET_COLS;
    logic [4:0] rows_reg = tcw_pkg::RESET_ROWS;
    logic shown_reg = 1'b0;

    tcw_pkg::rsp_t console_replies [$];
    tcw_pkg::rsp_t head_reply;
    int fail_count = 0;
    bit gaps_on = 1'b1;
    int stall_hold = 0;
    int stall_pick;

    text_console_writer #(
        .MAX_COLUMNS(SCREEN_COLS),
        .MAX_ROWS(SCREEN_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int eff_cols();
        if (cols_reg == 0)
            return 1;
        return (cols_reg > SCREEN_COLS) ? SCREEN_COLS : cols_reg;
    endfunction

    function automatic int eff_rows();
        if (rows_reg == 0)
            return 1;
        return (rows_reg > SCREEN_ROWS) ? SCREEN_ROWS : rows_reg;
    endfunction

    // Apply one request to the shadow console and return its reply
    function automatic tcw_pkg::rsp_t console_step(input tcw_pkg::req_t op);
        tcw_pkg::rsp_t rep;
        int w;
        int h;
        int x;
        int y;
        int i;
        logic [15:0] blank;
        w = eff_cols();
        h = eff_rows();
        blank = {attr_reg, tcw_pkg::SPACE_CODE};
        rep = '0;
        // pull the cursor back onto a shrunken screen
        if (cursor_col >= w)
            cursor_col = w - 1;
        if (cursor_row >= h)
            cursor_row = h - 1;
        case (op.mode)
            tcw_pkg::MODE_PUT:
            begin
                if (op.char_code == tcw_pkg::NEWLINE_CODE)
                begin
                    cursor_col = 0;
                    cursor_row++;
                end
                else
                begin
                    cells[cursor_row * w + cursor_col] = {attr_reg, op.char_code};
                    cursor_col++;
                    if (cursor_col == w)
                    begin
                        cursor_col = 0;
                        cursor_row++;
                    end
                end
                // scroll the used area up one row and blank the bottom row
                if (cursor_row == h)
                begin
                    for (i = 0; i < w * h; i++)
                        cells[i] = (i < w * (h - 1)) ? cells[i + w] : blank;
                    cursor_row--;
                    rep.scrolled = 1'b1;
                end
                rep.char_echo = op.char_code;
                rep.cursor_write = shown_reg;
            end
            tcw_pkg::MODE_CLEAR:
            begin
                foreach (cells[k])
                    cells[k] = blank;
            end
            tcw_pkg::MODE_SET:
            begin
                x = $signed(op.want_column);
                y = $signed(op.want_row);
                if (x < 0)
                    x = 0;
                else if (x >= w)
                    x = w - 1;
                if (y < 0)
                    y = 0;
                else if (y >= h)
                    y = h - 1;
                cursor_col = x;
                cursor_row = y;
                rep.cursor_write = shown_reg;
            end
            tcw_pkg::MODE_READ:
            begin
                if (op.cell_index < CELL_COUNT)
                    rep.cell_value = cells[op.cell_index];
            end
            default:
            begin
            end
        endcase
        rep.cursor_column = 7'(cursor_col);
        rep.cursor_row = 5'(cursor_row);
        rep.cursor_location = 11'(cursor_row * w + cursor_col);
        return rep;
    endfunction

    function automatic tcw_pkg::req_t mk_op(input logic [1:0] m, input logic [7:0] ch,
                                            input int col, input int row, input int idx);
        tcw_pkg::req_t op;
        op.mode = m;
        op.char_code = ch;
        op.want_column = 8'(col);
        op.want_row = 8'(row);
        op.cell_index = 11'(idx);
        return op;
    endfunction

    function automatic tcw_pkg::rsp_t mk_reply(input int echo, input int col, input int row,
                                               input int loc, input int wr, input int scr,
                                               input int value);
        tcw_pkg::rsp_t rep;
        rep.char_echo = 8'(echo);
        rep.cursor_column = 7'(col);
        rep.cursor_row = 5'(row);
        rep.cursor_location = 11'(loc);
        rep.cursor_write = 1'(wr);
        rep.scrolled = 1'(scr);
        rep.cell_value = 16'(value);
        return rep;
    endfunction

    // Hand one request over, record its reply, then at times idle a while
    task automatic send_op(input tcw_pkg::req_t op, input bit typed,
                           input tcw_pkg::rsp_t reply);
        tcw_pkg::rsp_t rep;
        int pick;
        int gap;
        req_valid <= 1'b1;
        req_data <= op;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        rep = console_step(op);
        console_replies.push_back(typed ? reply : rep);
        gap = 0;
        if (gaps_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 3);
            else if (pick < 95)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // Stall replies in bursts: short and long holds, and free stretches
    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                rsp_stall <= 1'b0;
                stall_hold <= $urandom_range(0, 3);
            end
            else if (stall_pick < 60)
            begin
                rsp_stall <= 1'b0;
                stall_hold <= $urandom_range(20, 60);
            end
            else if (stall_pick < 95)
            begin
                rsp_stall <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end
            else
            begin
                rsp_stall <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Compare each taken reply with the oldest one recorded
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (console_replies.size() == 0)
            begin
                fail_count++;
                $display("%0t: reply expected none got %p", $time, rsp_data);
            end
            else
            begin
                head_reply = console_replies.pop_front();
                check_field("char_echo", head_reply.char_echo, rsp_data.char_echo);
                check_field("cursor_column", head_reply.cursor_column,
                            rsp_data.cursor_column);
                check_field("cursor_row", head_reply.cursor_row, rsp_data.cursor_row);
                check_field("cursor_location", head_reply.cursor_location,
                            rsp_data.cursor_location);
                check_field("cursor_write", head_reply.cursor_write,
                            rsp_data.cursor_write);
                check_field("scrolled", head_reply.scrolled, rsp_data.scrolled);
                check_field("cell_value", head_reply.cell_value, rsp_data.cell_value);
            end
        end
    end

    initial
    begin
        step_row_t directed [$];
        logic [7:0] setting [4];
        logic [63:0] noise;
        tcw_pkg::req_t op;
        int ph;
        int k;
        int n;
        int pick;
        int w;
        int h;

        foreach (cells[i])
            cells[i] = tcw_pkg::RESET_CELL;

        // Directed requests on the reset screen
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 0), 1'b1,
                                       mk_reply(0, 0, 0, 0, 0, 0, tcw_pkg::RESET_CELL)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 8'hFF, -1, -1, 1999), 1'b1,
                                       mk_reply(0, 0, 0, 0, 0, 0, tcw_pkg::RESET_CELL)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 2000), 1'b1,
                                       mk_reply(0, 0, 0, 0, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 2047), 1'b1,
                                       mk_reply(0, 0, 0, 0, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, 8'h41, 0, 0, 0), 1'b1,
                                       mk_reply(8'h41, 1, 0, 1, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, 8'hFF, 127, 127, 2047), 1'b1,
                                       mk_reply(8'hFF, 2, 0, 2, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 1), 1'b1,
                                       mk_reply(0, 2, 0, 2, 0, 0, 16'h07FF)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, 8'h00, 0, 0, 0), 1'b0,
                                       '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE,
                                             0, 0, 0), 1'b1,
                                       mk_reply(tcw_pkg::NEWLINE_CODE, 0, 1, 80, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_SET, 0, 127, 127, 0), 1'b1,
                                       mk_reply(0, 79, 24, 1999, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_SET, 0, -128, -128, 0), 1'b1,
                                       mk_reply(0, 0, 0, 0, 0, 0, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_SET, 0, 79, 24, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, 8'h5A, 0, 0, 0), 1'b1,
                                       mk_reply(8'h5A, 0, 24, 1920, 0, 1, 0)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 1919), 1'b1,
                                       mk_reply(0, 0, 24, 1920, 0, 0, 16'h075A)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 1999), 1'b1,
                                       mk_reply(0, 0, 24, 1920, 0, 0,
                                                tcw_pkg::RESET_CELL)});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 80), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE,
                                             0, 0, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_CLEAR, 8'h55, 33, -7, 1234),
                                       1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 1), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_SET, 0, -1, 5, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_SET, 0, 80, -1, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_PUT, 8'h80, 0, 0, 0), 1'b0, '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 11'h400), 1'b0,
                                       '0});
        directed.push_back(step_row_t'{mk_op(tcw_pkg::MODE_READ, 0, 0, 0, 11'h7FF), 1'b0,
                                       '0});

        // Hold reset once at the start, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_op(directed[i].op, directed[i].typed, directed[i].reply);
        req_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++)
        begin
            // Pick the screen setup for this phase: extremes first, then small screens
            n = 45;
            case (ph)
                0:
                begin
                    setting[tcw_pkg::CFG_ATTRIBUTE] = 8'h00;
                    setting[tcw_pkg::CFG_COLUMNS] = 8'd1;
                    setting[tcw_pkg::CFG_ROWS] = 8'd1;
                    setting[tcw_pkg::CFG_CURSOR_SHOWN] = 8'd1;
                    n = 40;
                end
                1:
                begin
                    setting[tcw_pkg::CFG_ATTRIBUTE] = 8'hFF;
                    setting[tcw_pkg::CFG_COLUMNS] = 8'd0;
                    setting[tcw_pkg::CFG_ROWS] = 8'd0;
                    setting[tcw_pkg::CFG_CURSOR_SHOWN] = 8'd0;
                    n = 40;
                end
                2:
                begin
                    setting[tcw_pkg::CFG_ATTRIBUTE] = 8'($urandom);
                    setting[tcw_pkg::CFG_COLUMNS] = 8'(SCREEN_COLS);
                    setting[tcw_pkg::CFG_ROWS] = 8'(SCREEN_ROWS);
                    setting[tcw_pkg::CFG_CURSOR_SHOWN] = 8'd1;
                    n = 30;
                end
                3:
                begin
                    setting[tcw_pkg::CFG_ATTRIBUTE] = 8'($urandom);
                    setting[tcw_pkg::CFG_COLUMNS] = 8'h7F;
                    setting[tcw_pkg::CFG_ROWS] = 8'h1F;
                    setting[tcw_pkg::CFG_CURSOR_SHOWN] = 8'd0;
                    n = 25;
                end
                default:
                begin
                    setting[tcw_pkg::CFG_ATTRIBUTE] = 8'($urandom);
                    setting[tcw_pkg::CFG_COLUMNS] = {1'($urandom), 7'($urandom_range(1, 10))};
                    setting[tcw_pkg::CFG_ROWS] = {3'($urandom), 5'($urandom_range(1, 5))};
                    setting[tcw_pkg::CFG_CURSOR_SHOWN] = {7'($urandom), 1'($urandom)};
                end
            endcase
            gaps_on = (ph % 3 != 1);

            // Drain outstanding replies before touching the registers
            while (console_replies.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
            for (k = 0; k < 4; k++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= 2'(k);
                cfg_data <= setting[k];
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                case (2'(k))
                    tcw_pkg::CFG_ATTRIBUTE:    attr_reg = setting[k];
                    tcw_pkg::CFG_COLUMNS:      cols_reg = setting[k][6:0];
                    tcw_pkg::CFG_ROWS:         rows_reg = setting[k][4:0];
                    tcw_pkg::CFG_CURSOR_SHOWN: shown_reg = setting[k][0];
                    default:                   shown_reg = shown_reg;
                endcase
            end
            cfg_valid <= 1'b0;

            // Random requests, aimed mostly inside the screen in use
            w = eff_cols();
            h = eff_rows();
            for (k = 0; k < n; k++)
            begin
                noise = {$urandom, $urandom};
                op = noise[$bits(tcw_pkg::req_t)-1:0];
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op.mode = tcw_pkg::MODE_CLEAR;
                else if (pick < 20)
                    op.mode = tcw_pkg::MODE_SET;
                else if (pick < 40)
                    op.mode = tcw_pkg::MODE_READ;
                else
                    op.mode = tcw_pkg::MODE_PUT;
                if (op.mode == tcw_pkg::MODE_PUT && $urandom_range(0, 7) == 0)
                    op.char_code = tcw_pkg::NEWLINE_CODE;
                if (op.mode == tcw_pkg::MODE_SET && $urandom_range(0, 1) == 0)
                begin
                    op.want_column = 8'($urandom_range(0, w));
                    op.want_row = 8'($urandom_range(0, h));
                end
                if (op.mode == tcw_pkg::MODE_READ && $urandom_range(0, 3) != 0)
                    op.cell_index = 11'($urandom_range(0, w * h - 1));
                send_op(op, 1'b0, '0);
            end
            req_valid <= 1'b0;
        end

        // Wait out the last replies, then report
        while (console_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("text_console_writer: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
